@@ sv/bpa_pkg.sv @@
// bpa_pkg: shared constants of the buddy page allocator
// no dependencies
package bpa_pkg;

   // node kinds held in the node memory
   localparam logic [1:0] KIND_ABSENT = 2'd0;
   localparam logic [1:0] KIND_USED   = 2'd1;
   localparam logic [1:0] KIND_INNER  = 2'd2;
   localparam logic [1:0] KIND_FREE   = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_SIZE = 2'd1;
   localparam logic [1:0] ST_NO_SPACE = 2'd2;
   localparam logic [1:0] ST_BAD_FREE = 2'd3;

   // command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // configuration register indexes
   localparam logic CSR_POOL_BASE = 1'b0;
   localparam logic CSR_PHYS_TOP  = 1'b1;

   localparam int ADDR_W = 40;
   localparam int CNT_W  = 10;

endpackage

@@ sv/bpa_ram.sv @@
// bpa_ram: generic single-port synchronous ram with registered read
// no dependencies
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one access per cycle: an optional write, and a read of the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/buddy_page_allocator.sv @@
// buddy_page_allocator: top level, sequencer over node/link memory
// depends on bpa_pkg and bpa_ram
//
//  channel | ports                                   | handshake
//  request | req_command req_page_count req_free_address | start & !busy
//  result  | rsp_status rsp_block_address            | rsp_valid, one cycle
//  config  | csr_write csr_index csr_data            | csr_write
//
// One word is processed at a time, busy high until an accepted word has its
// result; a rejected word leaves busy low and has its result registered at the
// accepting edge. An alloc searches the levels upward, unlinks the head block
// and splits down level by level; a free walks down from the root and merges
// upward with free buddies, all through the single port of the node memory.
// After reset a clearing pass sweeps all 2*POOL_PAGES-1 entries (one a
// cycle) with busy high. The result strobe cannot be stalled.
module buddy_page_allocator #(
   parameter int POOL_PAGES  = 16384,
   parameter int TREE_LEVELS = 15,
   parameter int MAX_ALLOC_PAGES = 512,
   parameter int PAGE_BYTES  = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [9:0]  req_page_count,
   input  logic [39:0] req_free_address,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [39:0] rsp_block_address,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [39:0] csr_data
);

   localparam int NODES = 2 * POOL_PAGES - 1;
   localparam int NW    = $clog2(NODES + 1);
   localparam int LW    = $clog2(TREE_LEVELS + 1);
   localparam int PSH   = $clog2(PAGE_BYTES);
   localparam int PGW   = $clog2(POOL_PAGES + 1);
   localparam int MW    = 2 + 2 * NW;
   localparam logic [NW-1:0] NIL = NW'(NODES);

   // node memory word: kind, next, prev
   typedef struct packed {
      logic [1:0]    kind;
      logic [NW-1:0] next;
      logic [NW-1:0] prev;
   } entry_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_ASRCH, S_ATAKE, S_ARD, S_AUNL, S_AUNL_P, S_AUNL_PW,
      S_AUNL_N, S_AUNL_NW, S_SPLIT, S_SPLIT_W, S_PUSH, S_PUSH_H, S_PUSH_HW,
      S_PUSH_DONE, S_FWALK, S_FWALK_W, S_FBUD, S_FBUD_W, S_DONE
   } state_type;

   state_type state_ff;
   logic [39:0] pool_base_ff, phys_top_ff, free_ff;
   logic [NW-1:0] cur_ff, tgt_ff, clr_ff;
   logic [LW-1:0] lv_ff, want_ff, tlv_ff;
   logic [NW-1:0] head_ff [TREE_LEVELS];
   logic [NW-1:0] cnt_ff  [TREE_LEVELS];
   logic          cmd_ff, in_free_ff;
   logic [NW-1:0] pn_ff, nn_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [39:0]   rsp_addr_ff;

   logic          m_we;
   logic [NW-1:0] m_addr;
   entry_type     m_wd, m_rd;

   bpa_ram #(.WIDTH(MW), .DEPTH(NODES + 1)) u_nodes (
      .clock(clock), .wr_en(m_we), .addr(m_addr), .wr_data(m_wd), .rd_data(m_rd)
   );

   // level of a node: TREE_LEVELS-1-depth
   function automatic logic [LW-1:0] level_of(input logic [NW-1:0] i);
      logic [NW:0] v;
      logic [LW-1:0] d;
      v = {1'b0, i} + 1'b1;
      d = '0;
      for (int b = 1; b <= NW; b++) begin
         if (v[b]) d = LW'(b);
      end
      return (d < LW'(TREE_LEVELS)) ? LW'(TREE_LEVELS - 1) - d : '0;
   endfunction

   // page offset of a node inside the pool
   function automatic logic [PGW-1:0] page_of(input logic [NW-1:0] i);
      logic [NW:0] v;
      logic [LW-1:0] d;
      logic [NW:0] pos;
      logic [NW:0] pages;
      v = {1'b0, i} + 1'b1;
      d = '0;
      for (int b = 1; b <= NW; b++) begin
         if (v[b]) d = LW'(b);
      end
      pos = v & ~(({{NW{1'b0}}, 1'b1}) << d);
      pages = (NW+1)'(POOL_PAGES) >> d;
      return PGW'(pos * pages);
   endfunction

   // rounded base keeps its carry so address compares never wrap
   logic [40:0] base_rnd;
   assign base_rnd = ({1'b0, pool_base_ff} + 41'(PAGE_BYTES - 1)) & ~41'(PAGE_BYTES - 1);

   function automatic logic [40:0] addr_of(input logic [NW-1:0] i, input logic [40:0] b);
      return b + (41'(page_of(i)) << PSH);
   endfunction

   // request size decode
   localparam int CNT_W_L = bpa_pkg::CNT_W;
   logic size_ok;
   logic [LW-1:0] want_lv;
   always_comb begin
      want_lv = '0;
      for (int b = 0; b < CNT_W_L; b++) begin
         if (req_page_count[b]) want_lv = LW'(b);
      end
      size_ok = (req_page_count != '0) && ((req_page_count & (req_page_count - 1'b1)) == '0)
                && (32'(req_page_count) <= 32'(MAX_ALLOC_PAGES));
   end

   logic free_ok;
   assign free_ok = (req_free_address != '0) && (req_free_address[PSH-1:0] == '0)
                    && ({1'b0, req_free_address} >= base_rnd)
                    && (req_free_address < phys_top_ff);

   logic [NW-1:0] right_c, left_c, bud_c, par_c;
   assign right_c = NW'({1'b0, cur_ff, 1'b0} + 2);
   assign left_c  = NW'({1'b0, cur_ff, 1'b0} + 1);
   assign bud_c   = cur_ff[0] ? cur_ff + 1'b1 : cur_ff - 1'b1;
   assign par_c   = NW'((cur_ff - 1'b1) >> 1);
   logic has_kids;
   assign has_kids = ({1'b0, cur_ff, 1'b0} + 2) < (NW+1)'(NODES);

   // memory port drive
   always_comb begin
      m_we = 1'b0;
      m_addr = cur_ff;
      m_wd = '{kind: bpa_pkg::KIND_ABSENT, next: NIL, prev: NIL};
      unique case (state_ff)
         S_CLEAR: begin
            m_we = 1'b1; m_addr = clr_ff;
            m_wd = '{kind: (clr_ff == '0) ? bpa_pkg::KIND_FREE : bpa_pkg::KIND_ABSENT,
                     next: NIL, prev: NIL};
         end
         S_ARD, S_FBUD, S_FWALK: m_addr = tgt_ff;
         S_AUNL: begin
            m_we = 1'b1; m_addr = tgt_ff;
            m_wd = '{kind: in_free_ff ? bpa_pkg::KIND_ABSENT : bpa_pkg::KIND_FREE,
                     next: NIL, prev: NIL};
            if (!in_free_ff) m_wd.kind = bpa_pkg::KIND_USED;
         end
         S_AUNL_P: m_addr = pn_ff;
         S_AUNL_PW: begin
            m_we = 1'b1; m_addr = pn_ff; m_wd = m_rd; m_wd.next = nn_ff;
         end
         S_AUNL_N: m_addr = nn_ff;
         S_AUNL_NW: begin
            m_we = 1'b1; m_addr = nn_ff; m_wd = m_rd; m_wd.prev = pn_ff;
         end
         S_SPLIT: begin
            m_we = 1'b1; m_addr = cur_ff;
            m_wd = '{kind: bpa_pkg::KIND_INNER, next: NIL, prev: NIL};
         end
         S_PUSH: begin
            m_we = 1'b1; m_addr = tgt_ff;
            m_wd = '{kind: bpa_pkg::KIND_FREE, next: head_ff[tlv_ff], prev: NIL};
         end
         S_PUSH_H: m_addr = nn_ff;
         S_PUSH_HW: begin
            m_we = 1'b1; m_addr = nn_ff; m_wd = m_rd; m_wd.prev = tgt_ff;
         end
         S_DONE: begin
            m_we = !cmd_ff; m_addr = cur_ff;
            m_wd = '{kind: bpa_pkg::KIND_USED, next: NIL, prev: NIL};
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (csr_write) begin
         if (csr_index == bpa_pkg::CSR_POOL_BASE) pool_base_ff <= csr_data;
         else phys_top_ff <= csr_data;
      end
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         pool_base_ff <= 40'd2147483648;
         phys_top_ff <= 40'd2281701376;
         for (int l = 0; l < TREE_LEVELS; l++) begin
            head_ff[l] <= (l == TREE_LEVELS - 1) ? '0 : NIL;
            cnt_ff[l]  <= (l == TREE_LEVELS - 1) ? NW'(1) : '0;
         end
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == NW'(NODES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (start) begin
               cmd_ff <= req_command;
               free_ff <= req_free_address;
               if (req_command == bpa_pkg::CMD_ALLOC) begin
                  want_ff <= want_lv; lv_ff <= want_lv;
                  if (!size_ok) begin
                     rsp_valid_ff <= 1'b1; rsp_status_ff <= bpa_pkg::ST_BAD_SIZE;
                     rsp_addr_ff <= '0;
                  end else state_ff <= S_ASRCH;
               end else if (!free_ok) begin
                  rsp_valid_ff <= 1'b1; rsp_status_ff <= bpa_pkg::ST_BAD_FREE;
                  rsp_addr_ff <= '0;
               end else begin
                  tgt_ff <= '0; cur_ff <= '0; state_ff <= S_FWALK;
               end
            end
            // scan levels upward for a nonempty list
            S_ASRCH: begin
               if (lv_ff >= LW'(TREE_LEVELS)) begin
                  rsp_valid_ff <= 1'b1; rsp_status_ff <= bpa_pkg::ST_NO_SPACE;
                  rsp_addr_ff <= '0; state_ff <= S_IDLE;
               end else if (cnt_ff[lv_ff] != '0 && head_ff[lv_ff] < NIL) begin
                  tgt_ff <= head_ff[lv_ff]; cur_ff <= head_ff[lv_ff];
                  tlv_ff <= lv_ff; in_free_ff <= 1'b0; state_ff <= S_ARD;
               end else lv_ff <= lv_ff + 1'b1;
            end
            // unlink tgt_ff from list tlv_ff
            S_ARD: state_ff <= S_ATAKE;
            S_ATAKE: begin
               pn_ff <= m_rd.prev; nn_ff <= m_rd.next; state_ff <= S_AUNL;
            end
            S_AUNL: begin
               if (cnt_ff[tlv_ff] != '0) cnt_ff[tlv_ff] <= cnt_ff[tlv_ff] - 1'b1;
               if (pn_ff < NIL) state_ff <= S_AUNL_P;
               else begin
                  head_ff[tlv_ff] <= nn_ff;
                  state_ff <= (nn_ff < NIL) ? S_AUNL_N : S_PUSH_DONE;
               end
            end
            S_AUNL_P: state_ff <= S_AUNL_PW;
            S_AUNL_PW: state_ff <= (nn_ff < NIL) ? S_AUNL_N : S_PUSH_DONE;
            S_AUNL_N: state_ff <= S_AUNL_NW;
            S_AUNL_NW: state_ff <= S_PUSH_DONE;
            // split one level down, pushing right child
            S_SPLIT: begin
               tgt_ff <= right_c; tlv_ff <= level_of(right_c);
               cur_ff <= left_c; state_ff <= S_PUSH;
            end
            S_PUSH: begin
               nn_ff <= head_ff[tlv_ff];
               head_ff[tlv_ff] <= tgt_ff;
               cnt_ff[tlv_ff] <= cnt_ff[tlv_ff] + 1'b1;
               state_ff <= (head_ff[tlv_ff] < NIL) ? S_PUSH_H : S_PUSH_DONE;
            end
            S_PUSH_H: state_ff <= S_PUSH_HW;
            S_PUSH_HW: state_ff <= S_PUSH_DONE;
            // decide after a list update
            S_PUSH_DONE: begin
               if (!cmd_ff) begin
                  if (level_of(cur_ff) > want_ff && has_kids) state_ff <= S_SPLIT;
                  else state_ff <= S_DONE;
               end else if (in_free_ff) begin
                  // buddy unlinked, move up
                  in_free_ff <= 1'b0; cur_ff <= par_c;
                  if (par_c == '0) begin
                     tgt_ff <= '0; tlv_ff <= level_of('0); state_ff <= S_PUSH;
                  end else begin
                     tgt_ff <= par_c[0] ? par_c + 1'b1 : par_c - 1'b1;
                     state_ff <= S_FBUD;
                  end
               end else begin
                  rsp_valid_ff <= 1'b1; rsp_status_ff <= bpa_pkg::ST_OK;
                  rsp_addr_ff <= '0; state_ff <= S_IDLE;
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1; rsp_status_ff <= bpa_pkg::ST_OK;
               rsp_addr_ff <= 40'(addr_of(cur_ff, base_rnd)); state_ff <= S_IDLE;
            end
            // free walk from the root
            S_FWALK: state_ff <= S_FWALK_W;
            S_FWALK_W: begin
               if (m_rd.kind == bpa_pkg::KIND_INNER && has_kids) begin
                  if (addr_of(right_c, base_rnd) > {1'b0, free_ff}) begin
                     cur_ff <= left_c; tgt_ff <= left_c;
                  end else begin
                     cur_ff <= right_c; tgt_ff <= right_c;
                  end
                  state_ff <= S_FWALK;
               end else if (m_rd.kind != bpa_pkg::KIND_USED
                            || addr_of(cur_ff, base_rnd) != {1'b0, free_ff}) begin
                  rsp_valid_ff <= 1'b1; rsp_status_ff <= bpa_pkg::ST_BAD_FREE;
                  rsp_addr_ff <= '0; state_ff <= S_IDLE;
               end else if (cur_ff == '0) begin
                  tgt_ff <= '0; tlv_ff <= level_of('0); state_ff <= S_PUSH;
               end else begin
                  tgt_ff <= bud_c; state_ff <= S_FBUD;
               end
            end
            // check buddy of cur_ff
            S_FBUD: state_ff <= S_FBUD_W;
            S_FBUD_W: begin
               if (tgt_ff < NIL && m_rd.kind == bpa_pkg::KIND_FREE) begin
                  pn_ff <= m_rd.prev; nn_ff <= m_rd.next;
                  tlv_ff <= level_of(tgt_ff); in_free_ff <= 1'b1;
                  state_ff <= S_AUNL;
               end else begin
                  tgt_ff <= cur_ff; tlv_ff <= level_of(cur_ff); state_ff <= S_PUSH;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_block_address = rsp_addr_ff;

endmodule

@@ dv/buddy_page_allocator_test.sv @@
// buddy_page_allocator_test: self-checking bench for the buddy page allocator
// depends on bpa_pkg and the buddy_page_allocator rtl; keeps its own copy of
// the tree and free lists and checks every result word against it or a typed row
module buddy_page_allocator_test;

   localparam int POOL      = 16384;
   localparam int LEVELS    = 15;
   localparam int MAX_PAGES = 512;
   localparam int PAGE      = 4096;
   localparam int NODES     = 2 * POOL - 1;
   localparam int NIL       = NODES;
   localparam longint unsigned MASK40 = 64'hFF_FFFF_FFFF;
   localparam int LIMIT     = 1500000;
   localparam int PHASE_WORDS = 150;

   typedef struct packed {
      logic        cmd;
      logic [9:0]  count;
      logic [39:0] addr;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [39:0] addr;
   } rsp_word_type;

   // directed row: request plus an optional typed expectation
   typedef struct packed {
      req_word_type word;
      logic         typed;
      rsp_word_type want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = bpa_pkg::CMD_ALLOC;
   logic [9:0]  req_page_count = '0;
   logic [39:0] req_free_address = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [39:0] rsp_block_address;
   logic        csr_write = 1'b0;
   logic        csr_index = bpa_pkg::CSR_POOL_BASE;
   logic [39:0] csr_data = '0;

   buddy_page_allocator uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_page_count(req_page_count),
      .req_free_address(req_free_address), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_block_address(rsp_block_address),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow allocator state
   logic [1:0]      kind_mem [NODES];
   int unsigned     link_next [NODES];
   int unsigned     link_prev [NODES];
   int unsigned     list_head [LEVELS];
   int unsigned     list_len  [LEVELS];
   longint unsigned shadow_pool_base;
   longint unsigned shadow_phys_top;

   rsp_word_type    expected_words [$];
   longint unsigned live_offsets [$];
   int              errors = 0;
   int              cycles = 0;
   bit              start_held = 1'b0;

   function automatic int unsigned node_depth(int unsigned i);
      int unsigned v, d;
      v = i + 1;
      d = 0;
      while (v > 1) begin
         v = v >> 1;
         d++;
      end
      return d;
   endfunction

   function automatic int unsigned node_level(int unsigned i);
      int unsigned d;
      d = node_depth(i);
      return (d < LEVELS) ? LEVELS - 1 - d : 0;
   endfunction

   function automatic longint unsigned pool_start();
      return ((shadow_pool_base + PAGE - 1) / PAGE) * PAGE;
   endfunction

   function automatic longint unsigned node_addr(int unsigned i);
      int unsigned d;
      longint unsigned pos;
      d = node_depth(i);
      pos = i - ((1 << d) - 1);
      return pool_start() + pos * (longint'(POOL) >> d) * PAGE;
   endfunction

   function automatic void list_push(int unsigned i);
      int unsigned lv, h;
      lv = node_level(i);
      h = list_head[lv];
      link_next[i] = h;
      link_prev[i] = NIL;
      if (h < NODES) link_prev[h] = i;
      list_head[lv] = i;
      list_len[lv]++;
      kind_mem[i] = bpa_pkg::KIND_FREE;
   endfunction

   function automatic void list_unlink(int unsigned i);
      int unsigned lv, p, n;
      lv = node_level(i);
      p = link_prev[i];
      n = link_next[i];
      if (p < NODES) link_next[p] = n;
      else list_head[lv] = n;
      if (n < NODES) link_prev[n] = p;
      if (list_len[lv] > 0) list_len[lv]--;
      link_prev[i] = NIL;
      link_next[i] = NIL;
   endfunction

   function automatic void shadow_reset();
      for (int i = 0; i < NODES; i++) begin
         kind_mem[i] = bpa_pkg::KIND_ABSENT;
         link_next[i] = NIL;
         link_prev[i] = NIL;
      end
      for (int l = 0; l < LEVELS; l++) begin
         list_head[l] = NIL;
         list_len[l] = 0;
      end
      shadow_pool_base = 64'd2147483648;
      shadow_phys_top = 64'd2281701376;
      list_push(0);
   endfunction

   // allocation: status plus the full-width block address
   function automatic logic [1:0] shadow_alloc(int unsigned n, output longint unsigned addr);
      int unsigned want, lv, cur;
      addr = 0;
      if (n == 0 || n > MAX_PAGES || (n & (n - 1)) != 0) return bpa_pkg::ST_BAD_SIZE;
      want = 0;
      while ((1 << want) < n) want++;
      for (lv = want; lv < LEVELS; lv++)
         if (list_len[lv] > 0 && list_head[lv] < NODES) break;
      if (lv >= LEVELS) return bpa_pkg::ST_NO_SPACE;
      cur = list_head[lv];
      list_unlink(cur);
      while (node_level(cur) > want && 2 * cur + 2 < NODES) begin
         kind_mem[cur] = bpa_pkg::KIND_INNER;
         list_push(2 * cur + 2);
         cur = 2 * cur + 1;
      end
      kind_mem[cur] = bpa_pkg::KIND_USED;
      addr = node_addr(cur);
      return bpa_pkg::ST_OK;
   endfunction

   // free: walk down, check for a used block start, then merge upward
   function automatic logic [1:0] shadow_free(longint unsigned pa);
      int unsigned cur, bud;
      cur = 0;
      if (pa == 0 || pa % PAGE != 0 || pa < pool_start() || pa >= shadow_phys_top)
         return bpa_pkg::ST_BAD_FREE;
      while (kind_mem[cur] == bpa_pkg::KIND_INNER && 2 * cur + 2 < NODES) begin
         if (node_addr(2 * cur + 2) > pa) cur = 2 * cur + 1;
         else cur = 2 * cur + 2;
      end
      if (kind_mem[cur] != bpa_pkg::KIND_USED || node_addr(cur) != pa)
         return bpa_pkg::ST_BAD_FREE;
      while (cur != 0) begin
         bud = (cur & 1) ? cur + 1 : cur - 1;
         if (bud >= NODES || kind_mem[bud] != bpa_pkg::KIND_FREE) break;
         kind_mem[cur] = bpa_pkg::KIND_ABSENT;
         kind_mem[bud] = bpa_pkg::KIND_ABSENT;
         list_unlink(bud);
         cur = (cur - 1) / 2;
      end
      list_push(cur);
      return bpa_pkg::ST_OK;
   endfunction

   // predicted result word for one accepted request; tracks live blocks
   function automatic rsp_word_type predict_word(req_word_type w);
      rsp_word_type r;
      longint unsigned full;
      full = 0;
      if (w.cmd == bpa_pkg::CMD_ALLOC) begin
         r.status = shadow_alloc(w.count, full);
         if (r.status == bpa_pkg::ST_OK) live_offsets.push_back(full - pool_start());
      end else begin
         r.status = shadow_free(w.addr);
      end
      r.addr = (r.status == bpa_pkg::ST_OK) ? 40'(full & MASK40) : '0;
      return r;
   endfunction

   // drive one request word and hold it until the block takes it
   task automatic send_word(req_word_type w, logic typed, rsp_word_type want);
      rsp_word_type p;
      start <= 1'b1;
      req_command <= w.cmd;
      req_page_count <= w.count;
      req_free_address <= w.addr;
      do @(posedge clock); while (busy);
      p = predict_word(w);
      expected_words.push_back(typed ? want : p);
   endtask

   // gap after a word: mostly none or short, now and then long
   task automatic idle_gap();
      int g;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: g = 0;
         9: g = $urandom_range(20, 150);
         default: g = $urandom_range(1, 4);
      endcase
      start_held = (g == 0);
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      if (start_held) start <= 1'b0;
      start_held = 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [39:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == bpa_pkg::CSR_POOL_BASE) shadow_pool_base = 64'(value);
      else shadow_phys_top = 64'(value);
      @(posedge clock);
   endtask

   function automatic req_word_type random_word();
      req_word_type w;
      int r, k, pick;
      r = $urandom_range(0, 99);
      w.cmd = bpa_pkg::CMD_ALLOC;
      w.count = 10'd1;
      w.addr = 40'($urandom());
      if (r >= 50 && r < 85 && live_offsets.size() != 0) begin
         // free of a block that is live
         pick = $urandom_range(0, live_offsets.size() - 1);
         w.cmd = bpa_pkg::CMD_FREE;
         w.addr = 40'((pool_start() + live_offsets[pick]) & MASK40);
         live_offsets.delete(pick);
      end else if (r >= 85 && r < 92) begin
         // page inside the pool: double free or free into a block middle
         w.cmd = bpa_pkg::CMD_FREE;
         w.addr = 40'((pool_start() + longint'($urandom_range(0, POOL - 1)) * PAGE)
                      & MASK40);
      end else if (r >= 92) begin
         // noise over every bit
         w.cmd = 1'($urandom_range(0, 1));
         w.count = 10'($urandom());
         w.addr = 40'({$urandom(), $urandom()});
      end else begin
         k = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
         w.count = 10'(1 << k);
      end
      return w;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected result status %0d addr %h", $time,
                     rsp_status, rsp_block_address);
            errors++;
         end else begin
            e = expected_words.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_block_address !== e.addr) begin
               $display("%0t: block_address expected %h actual %h", $time, e.addr,
                        rsp_block_address);
               errors++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("** buddy_page_allocator: FAILED **");
         $finish;
      end
   end

   row_type directed [17];
   logic [39:0] phase_base [6];
   logic [39:0] phase_top [6];

   initial begin
      rsp_word_type none;
      none = '0;
      // rows: request, typed flag, typed expectation
      directed[0]  = '{'{bpa_pkg::CMD_ALLOC, 10'd0, 40'h0}, 1'b1,
                       '{bpa_pkg::ST_BAD_SIZE, 40'h0}};
      directed[1]  = '{'{bpa_pkg::CMD_ALLOC, 10'd3, 40'h0}, 1'b1,
                       '{bpa_pkg::ST_BAD_SIZE, 40'h0}};
      directed[2]  = '{'{bpa_pkg::CMD_ALLOC, 10'd1023, 40'h0}, 1'b1,
                       '{bpa_pkg::ST_BAD_SIZE, 40'h0}};
      directed[3]  = '{'{bpa_pkg::CMD_ALLOC, 10'd513, 40'h0}, 1'b1,
                       '{bpa_pkg::ST_BAD_SIZE, 40'h0}};
      directed[4]  = '{'{bpa_pkg::CMD_ALLOC, 10'd1, 40'h0}, 1'b1,
                       '{bpa_pkg::ST_OK, 40'h00_8000_0000}};
      directed[5]  = '{'{bpa_pkg::CMD_ALLOC, 10'd512, 40'h0}, 1'b0, none};
      directed[6]  = '{'{bpa_pkg::CMD_ALLOC, 10'd1, 40'h0}, 1'b0, none};
      directed[7]  = '{'{bpa_pkg::CMD_FREE, 10'd0, 40'h0}, 1'b1,
                       '{bpa_pkg::ST_BAD_FREE, 40'h0}};
      directed[8]  = '{'{bpa_pkg::CMD_FREE, 10'd0, 40'h00_8000_0800}, 1'b1,
                       '{bpa_pkg::ST_BAD_FREE, 40'h0}};
      directed[9]  = '{'{bpa_pkg::CMD_FREE, 10'd0, 40'h00_7FFF_F000}, 1'b1,
                       '{bpa_pkg::ST_BAD_FREE, 40'h0}};
      directed[10] = '{'{bpa_pkg::CMD_FREE, 10'd0, 40'h00_8800_0000}, 1'b1,
                       '{bpa_pkg::ST_BAD_FREE, 40'h0}};
      directed[11] = '{'{bpa_pkg::CMD_FREE, 10'd0, 40'hFF_FFFF_F000}, 1'b1,
                       '{bpa_pkg::ST_BAD_FREE, 40'h0}};
      directed[12] = '{'{bpa_pkg::CMD_FREE, 10'd0, 40'h00_8000_3000}, 1'b0, none};
      directed[13] = '{'{bpa_pkg::CMD_FREE, 10'd0, 40'h00_8000_0000}, 1'b0, none};
      directed[14] = '{'{bpa_pkg::CMD_FREE, 10'd0, 40'h00_8000_0000}, 1'b0, none};
      directed[15] = '{'{bpa_pkg::CMD_ALLOC, 10'd256, 40'h0}, 1'b0, none};
      directed[16] = '{'{bpa_pkg::CMD_FREE, 10'd0, 40'h00_8020_0000}, 1'b0, none};

      // register settings per random phase, extremes included
      phase_base[0] = 40'h00_8000_0000; phase_top[0] = 40'h00_8800_0000;
      phase_base[1] = 40'h00_1234_5001; phase_top[1] = 40'hFF_FFFF_FFFF;
      phase_base[2] = 40'h00_0000_0000; phase_top[2] = 40'h00_0200_0000;
      phase_base[3] = 40'hFF_FC00_0000; phase_top[3] = 40'hFF_FFFF_FFFF;
      phase_base[4] = 40'hFF_FFFF_FFFF; phase_top[4] = 40'h00_0000_0000;
      phase_base[5] = 40'h00_8000_0000; phase_top[5] = 40'h00_8800_0000;

      shadow_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table under reset settings
      foreach (directed[i]) begin
         send_word(directed[i].word, directed[i].typed, directed[i].want);
         idle_gap();
      end

      // random phases, registers rewritten while idle
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_csr(bpa_pkg::CSR_POOL_BASE, phase_base[ph]);
         write_csr(bpa_pkg::CSR_PHYS_TOP, phase_top[ph]);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            send_word(random_word(), 1'b0, none);
            idle_gap();
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("** buddy_page_allocator: PASSED **");
      else
         $display("** buddy_page_allocator: FAILED **");
      $finish;
   end

endmodule
